@@ hw/rtl/polygon_point_hit_test_top_assert.svh @@
// Assertion macros for the polygon point hit test checker.
// Included by the checker file only; no other dependencies.
`ifndef POLYGON_POINT_HIT_TEST_TOP_ASSERT_SVH
`define POLYGON_POINT_HIT_TEST_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define PPHT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define PPHT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ppht_pkg.sv @@
// Shared types, codes and the per-edge multiply sequence of the hit test.
// No dependencies; imported by every RTL module of the block but ppht_ram.
`default_nettype none

package ppht_pkg;

    localparam int DEF_MAX_VERTICES = 256;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] CFG_EDGE_TOL  = 2'd0;
    localparam logic [1:0] CFG_CROSS_TOL = 2'd1;
    localparam logic [1:0] CFG_CLOSE_TOL = 2'd2;

    localparam logic [15:0] RST_EDGE_TOL  = 16'd6554;
    localparam logic [15:0] RST_CROSS_TOL = 16'd66;
    localparam logic [15:0] RST_CLOSE_TOL = 16'd6554;

    // request modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int VC_W    = 9;
    localparam int OUT_W   = 16;
    localparam int STEP_W  = 5;

    localparam logic [STEP_W-1:0] STEP_EDGE_LAST = 5'd22;
    localparam logic [STEP_W-1:0] STEP_B2_FIRST  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_B2_LAST   = 5'd5;

    // multiplier operand codes
    localparam logic [3:0] OP_AX   = 4'd0;
    localparam logic [3:0] OP_AY   = 4'd1;
    localparam logic [3:0] OP_CX   = 4'd2;
    localparam logic [3:0] OP_CY   = 4'd3;
    localparam logic [3:0] OP_UX   = 4'd4;
    localparam logic [3:0] OP_UY   = 4'd5;
    localparam logic [3:0] OP_BMIN = 4'd6;
    localparam logic [3:0] OP_BMAX = 4'd7;
    localparam logic [3:0] OP_CT   = 4'd8;
    localparam logic [3:0] OP_CRHI = 4'd9;
    localparam logic [3:0] OP_CRLO = 4'd10;
    localparam logic [3:0] OP_ET2  = 4'd11;
    localparam logic [3:0] OP_BHI  = 4'd12;
    localparam logic [3:0] OP_BLO  = 4'd13;

    // accumulator shift codes
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_33 = 2'd1;
    localparam logic [1:0] SH_66 = 2'd2;

    // result destinations
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_A2   = 4'd1;
    localparam logic [3:0] DST_C2   = 4'd2;
    localparam logic [3:0] DST_B2   = 4'd3;
    localparam logic [3:0] DST_DB   = 4'd4;
    localparam logic [3:0] DST_DE   = 4'd5;
    localparam logic [3:0] DST_CR   = 4'd6;
    localparam logic [3:0] DST_CTUY = 4'd7;
    localparam logic [3:0] DST_TMIN = 4'd8;
    localparam logic [3:0] DST_TMAX = 4'd9;
    localparam logic [3:0] DST_EB   = 4'd10;
    localparam logic [3:0] DST_CRSQ = 4'd11;

    typedef struct packed {
        logic [3:0] opa;
        logic [3:0] opb;
        logic       neg;
        logic [1:0] sh;
        logic       first;
        logic [3:0] dest;
    } t_uop;

    typedef struct packed {
        logic              ram_we;
        logic              ram_re;
        logic              load_pt;
        logic              load_b;
        logic              load_e;
        logic              shift_b;
        logic              mul_en;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic near;
        logic crhit;
        logic toggle;
        logic close_lt;
    } t_stat;

    function automatic t_uop mk(input logic [3:0] a, input logic [3:0] b, input logic n,
                                input logic [1:0] s, input logic f, input logic [3:0] d);
        t_uop u;
        u.opa = a; u.opb = b; u.neg = n; u.sh = s; u.first = f; u.dest = d;
        return u;
    endfunction

    // one product per step; sums close on the step that names a destination
    function automatic t_uop uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk(OP_AX,   OP_AX,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd1:  u = mk(OP_AY,   OP_AY,   1'b0, SH_0,  1'b0, DST_A2);
            5'd2:  u = mk(OP_CX,   OP_CX,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd3:  u = mk(OP_CY,   OP_CY,   1'b0, SH_0,  1'b0, DST_C2);
            5'd4:  u = mk(OP_UX,   OP_UX,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd5:  u = mk(OP_UY,   OP_UY,   1'b0, SH_0,  1'b0, DST_B2);
            5'd6:  u = mk(OP_AX,   OP_UX,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd7:  u = mk(OP_AY,   OP_UY,   1'b0, SH_0,  1'b0, DST_DB);
            5'd8:  u = mk(OP_CX,   OP_UX,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd9:  u = mk(OP_CY,   OP_UY,   1'b0, SH_0,  1'b0, DST_DE);
            5'd10: u = mk(OP_UX,   OP_AY,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd11: u = mk(OP_UY,   OP_AX,   1'b1, SH_0,  1'b0, DST_CR);
            5'd12: u = mk(OP_CT,   OP_UY,   1'b0, SH_0,  1'b1, DST_CTUY);
            5'd13: u = mk(OP_BMIN, OP_UY,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd14: u = mk(OP_UX,   OP_AY,   1'b0, SH_0,  1'b0, DST_TMIN);
            5'd15: u = mk(OP_BMAX, OP_UY,   1'b0, SH_0,  1'b1, DST_NONE);
            5'd16: u = mk(OP_UX,   OP_AY,   1'b0, SH_0,  1'b0, DST_TMAX);
            5'd17: u = mk(OP_ET2,  OP_BHI,  1'b0, SH_33, 1'b1, DST_NONE);
            5'd18: u = mk(OP_ET2,  OP_BLO,  1'b0, SH_0,  1'b0, DST_EB);
            5'd19: u = mk(OP_CRHI, OP_CRHI, 1'b0, SH_66, 1'b1, DST_NONE);
            5'd20: u = mk(OP_CRHI, OP_CRLO, 1'b0, SH_33, 1'b0, DST_NONE);
            5'd21: u = mk(OP_CRLO, OP_CRHI, 1'b0, SH_33, 1'b0, DST_NONE);
            5'd22: u = mk(OP_CRLO, OP_CRLO, 1'b0, SH_0,  1'b0, DST_CRSQ);
            default: u = mk(OP_AX, OP_AX,   1'b0, SH_0,  1'b1, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ppht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppht_ram #(
    parameter int W = 64,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ppht_ctrl.sv @@
// Sequencer of the hit test: request handshake, vertex count, edge walk,
// result register. Depends on ppht_pkg.
`default_nettype none

module ppht_ctrl
    import ppht_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_mode,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_hit,
    output logic                                 o_status,
    output logic [VC_W-1:0]                      o_vcount,
    output t_cmd                                 o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]      o_addr,
    input  wire t_stat                           i_stat
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WRITE   = 4'd1;
    localparam logic [3:0] S_P_RD0   = 4'd2;
    localparam logic [3:0] S_P_RD1   = 4'd3;
    localparam logic [3:0] S_P_LD    = 4'd4;
    localparam logic [3:0] S_P_RUN   = 4'd5;
    localparam logic [3:0] S_P_DRAIN = 4'd6;
    localparam logic [3:0] S_P_CHK   = 4'd7;
    localparam logic [3:0] S_E_RD    = 4'd8;
    localparam logic [3:0] S_E_LD    = 4'd9;
    localparam logic [3:0] S_E_RUN   = 4'd10;
    localparam logic [3:0] S_E_DRAIN = 4'd11;
    localparam logic [3:0] S_E_EVAL  = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_parity, n_parity;
    logic              r_res_hit, n_res_hit;
    logic              r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    logic              r_out_status, n_out_status;
    logic [CW-1:0]     r_out_vc, n_out_vc;
    logic [CW-1:0]     cnt_m1;
    logic              accept;

    assign cnt_m1      = r_count - CW'(1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_status    = r_out_status;
    assign o_vcount    = VC_W'(r_out_vc);

    always_comb begin
        o_addr = '0;
        case (r_state)
            S_WRITE: o_addr = r_count[AW-1:0];
            S_P_RD1: o_addr = cnt_m1[AW-1:0];
            S_E_RD:  o_addr = r_idx[AW-1:0];
            default: o_addr = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_step       = r_step;
        n_parity     = r_parity;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_hit    = r_out_hit;
        n_out_status = r_out_status;
        n_out_vc     = r_out_vc;
        o_cmd        = '0;
        o_cmd.step   = r_step;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_pt = 1'b1;
                    n_res_hit     = 1'b0;
                    n_res_status  = 1'b0;
                    n_state       = S_DONE;
                    case (i_mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_APPEND: begin
                            if (r_count < CW'(MAX_VERTICES)) begin
                                n_state = S_WRITE;
                            end else begin
                                n_res_status = 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            if (r_count >= CW'(3)) begin
                                n_state = S_P_RD0;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.ram_we = 1'b1;
                n_count      = r_count + CW'(1);
                n_state      = S_DONE;
            end
            S_P_RD0: begin
                o_cmd.ram_re = 1'b1;
                n_state      = S_P_RD1;
            end
            S_P_RD1: begin
                o_cmd.ram_re = 1'b1;
                o_cmd.load_b = 1'b1;
                n_state      = S_P_LD;
            end
            S_P_LD: begin
                o_cmd.load_e = 1'b1;
                n_step       = STEP_B2_FIRST;
                n_state      = S_P_RUN;
            end
            S_P_RUN: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_B2_LAST) begin
                    n_state = S_P_DRAIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_P_DRAIN: n_state = S_P_CHK;
            S_P_CHK: begin
                // closing vertex folded onto the first leaves only two
                if (i_stat.close_lt && r_count == CW'(3)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_b = 1'b1;
                    n_idx         = '0;
                    n_parity      = 1'b0;
                    n_state       = S_E_RD;
                end
            end
            S_E_RD: begin
                o_cmd.ram_re = 1'b1;
                n_state      = S_E_LD;
            end
            S_E_LD: begin
                o_cmd.load_e = 1'b1;
                n_step       = '0;
                n_state      = S_E_RUN;
            end
            S_E_RUN: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == STEP_EDGE_LAST) begin
                    n_state = S_E_DRAIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_E_DRAIN: n_state = S_E_EVAL;
            S_E_EVAL: begin
                if (i_stat.near || i_stat.crhit) begin
                    n_res_hit = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_parity      = r_parity ^ i_stat.toggle;
                    o_cmd.shift_b = 1'b1;
                    if (r_idx == cnt_m1) begin
                        n_res_hit = r_parity ^ i_stat.toggle;
                        n_state   = S_DONE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_E_RD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = r_res_hit;
                    n_out_status = r_res_status;
                    n_out_vc     = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_step      <= '0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_parity    <= n_parity;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
        r_out_hit    <= n_out_hit;
        r_out_status <= n_out_status;
        r_out_vc     <= n_out_vc;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ppht_datapath.sv @@
// Vertex store, shared 34x34 multiplier with wide accumulator, edge tests.
// Depends on ppht_pkg and ppht_ram.
`default_nettype none

module ppht_datapath
    import ppht_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] i_addr,
    input  wire logic signed [31:0]          i_px,
    input  wire logic signed [31:0]          i_py,
    input  wire logic [15:0]                 i_edge_tol,
    input  wire logic [15:0]                 i_cross_tol,
    input  wire logic [15:0]                 i_close_tol,
    output t_stat                            o_stat
);

    logic signed [31:0] r_px, r_py, r_bx, r_by, r_ex, r_ey;
    logic [63:0]        rdata;
    logic [31:0]        r_et2, r_ct2, r_cl2;

    ppht_ram #(.W(64), .D(MAX_VERTICES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_addr),
        .i_wdata ({r_py, r_px}),
        .i_re    (i_cmd.ram_re),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_et2 <= {16'd0, i_edge_tol}  * {16'd0, i_edge_tol};
        r_ct2 <= {16'd0, i_cross_tol} * {16'd0, i_cross_tol};
        r_cl2 <= {16'd0, i_close_tol} * {16'd0, i_close_tol};
        if (i_cmd.load_pt) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        if (i_cmd.load_b) begin
            r_bx <= rdata[31:0];
            r_by <= rdata[63:32];
        end else if (i_cmd.shift_b) begin
            r_bx <= r_ex;
            r_by <= r_ey;
        end
        if (i_cmd.load_e) begin
            r_ex <= rdata[31:0];
            r_ey <= rdata[63:32];
        end
    end

    // edge differences
    logic signed [32:0] ax, ay, cx, cy, ux, uy;
    logic signed [31:0] minx, maxx, miny, maxy;
    logic signed [33:0] bmin, bmax, ct34;

    assign ax   = {r_px[31], r_px} - {r_bx[31], r_bx};
    assign ay   = {r_py[31], r_py} - {r_by[31], r_by};
    assign cx   = {r_px[31], r_px} - {r_ex[31], r_ex};
    assign cy   = {r_py[31], r_py} - {r_ey[31], r_ey};
    assign ux   = {r_ex[31], r_ex} - {r_bx[31], r_bx};
    assign uy   = {r_ey[31], r_ey} - {r_by[31], r_by};
    assign minx = (r_bx < r_ex) ? r_bx : r_ex;
    assign maxx = (r_bx < r_ex) ? r_ex : r_bx;
    assign miny = (r_by < r_ey) ? r_by : r_ey;
    assign maxy = (r_by < r_ey) ? r_ey : r_by;
    assign ct34 = {18'd0, i_cross_tol};
    assign bmin = {{2{r_bx[31]}}, r_bx} - {{2{minx[31]}}, minx} + ct34;
    assign bmax = {{2{r_bx[31]}}, r_bx} - {{2{maxx[31]}}, maxx} - ct34;

    // stored sums
    logic [66:0]         r_a2, r_c2, r_b2;
    logic signed [67:0]  r_db, r_de, r_cr, r_tmin, r_tmax;
    logic signed [51:0]  r_ctuy;
    logic [99:0]         r_eb;
    logic [133:0]        r_crsq;

    logic [67:0]        abscr;
    logic signed [33:0] crhi, crlo, bhi, blo, et2op;

    assign abscr = r_cr[67] ? 68'(-r_cr) : 68'(r_cr);
    assign crhi  = {1'b0, abscr[65:33]};
    assign crlo  = {1'b0, abscr[32:0]};
    assign bhi   = {1'b0, r_b2[65:33]};
    assign blo   = {1'b0, r_b2[32:0]};
    assign et2op = {2'd0, r_et2};

    // issue stage
    t_uop               u_iss;
    logic signed [33:0] opa, opb;
    logic signed [67:0] r_prod;
    logic               r_pv;
    logic [STEP_W-1:0]  r_tag;

    assign u_iss = uop(i_cmd.step);

    always_comb begin
        case (u_iss.opa)
            OP_AX:   opa = 34'(ax);
            OP_AY:   opa = 34'(ay);
            OP_CX:   opa = 34'(cx);
            OP_UX:   opa = 34'(ux);
            OP_UY:   opa = 34'(uy);
            OP_CY:   opa = 34'(cy);
            OP_BMIN: opa = bmin;
            OP_BMAX: opa = bmax;
            OP_CT:   opa = ct34;
            OP_CRHI: opa = crhi;
            OP_CRLO: opa = crlo;
            OP_ET2:  opa = et2op;
            default: opa = '0;
        endcase
        case (u_iss.opb)
            OP_AX:   opb = 34'(ax);
            OP_AY:   opb = 34'(ay);
            OP_CX:   opb = 34'(cx);
            OP_CY:   opb = 34'(cy);
            OP_UX:   opb = 34'(ux);
            OP_UY:   opb = 34'(uy);
            OP_CRHI: opb = crhi;
            OP_CRLO: opb = crlo;
            OP_BHI:  opb = bhi;
            OP_BLO:  opb = blo;
            default: opb = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
        r_tag  <= i_cmd.step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    // accumulate stage
    t_uop                u_acc;
    logic signed [135:0] r_acc, acc_n, ext, shd, base;

    assign u_acc = uop(r_tag);
    assign ext   = {{68{r_prod[67]}}, r_prod};
    assign base  = u_acc.first ? '0 : r_acc;

    always_comb begin
        case (u_acc.sh)
            SH_33:   shd = ext <<< 33;
            SH_66:   shd = ext <<< 66;
            default: shd = ext;
        endcase
        acc_n = u_acc.neg ? (base - shd) : (base + shd);
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= acc_n;
            case (u_acc.dest)
                DST_A2:   r_a2   <= acc_n[66:0];
                DST_C2:   r_c2   <= acc_n[66:0];
                DST_B2:   r_b2   <= acc_n[66:0];
                DST_DB:   r_db   <= acc_n[67:0];
                DST_DE:   r_de   <= acc_n[67:0];
                DST_CR:   r_cr   <= acc_n[67:0];
                DST_CTUY: r_ctuy <= acc_n[51:0];
                DST_TMIN: r_tmin <= acc_n[67:0];
                DST_TMAX: r_tmax <= acc_n[67:0];
                DST_EB:   r_eb   <= acc_n[99:0];
                DST_CRSQ: r_crsq <= acc_n[133:0];
                default: ;
            endcase
        end
    end

    // edge evaluation
    function automatic logic opp_s(input logic signed [67:0] t, input logic uneg);
        return (t != '0) && (t[67] != uneg);
    endfunction

    function automatic logic same_s(input logic signed [67:0] t, input logic uneg);
        return (t != '0) && (t[67] == uneg);
    endfunction

    logic [66:0]        ct2z, et2z;
    logic               near, both_ok;
    logic [32:0]        absuy;
    logic signed [33:0] py34, ylo, yhi, yhm;
    logic signed [67:0] tpm, tpp, ctuy68;
    logic               cv, uneg;

    assign ct2z    = {35'd0, r_ct2};
    assign et2z    = {35'd0, r_et2};
    assign both_ok = !r_db[67] && (r_de[67] || r_de == '0);
    assign near    = (r_a2 <= ct2z) || (r_c2 <= ct2z) ||
                     ((r_b2 <= ct2z) ? (r_a2 <= et2z) :
                      (both_ok ? (r_crsq <= {34'd0, r_eb})
                               : ((r_a2 <= et2z) || (r_c2 <= et2z))));

    assign uneg   = uy[32];
    assign absuy  = uneg ? 33'(-uy) : 33'(uy);
    assign py34   = {{2{r_py[31]}}, r_py};
    assign ylo    = {{2{miny[31]}}, miny} - ct34;
    assign yhi    = {{2{maxy[31]}}, maxy} + ct34;
    assign yhm    = {{2{maxy[31]}}, maxy} - ct34;
    assign ctuy68 = {{16{r_ctuy[51]}}, r_ctuy};
    assign tpm    = r_cr + ctuy68;
    assign tpp    = r_cr - ctuy68;

    assign cv = (absuy > {17'd0, i_cross_tol}) && !(py34 < ylo) && !(py34 > yhi) &&
                !opp_s(r_tmin, uneg) && !same_s(r_tmax, uneg);

    assign o_stat.near     = near;
    assign o_stat.crhit    = cv && !opp_s(tpm, uneg) && !same_s(tpp, uneg);
    assign o_stat.toggle   = cv && same_s(r_cr, uneg) && (py34 < yhm) && (py34 >= ylo);
    assign o_stat.close_lt = r_b2 < {35'd0, r_cl2};

endmodule

`default_nettype wire

@@ hw/rtl/polygon_point_hit_test_top.sv @@
// Top level of the polygon point hit test: configuration registers, streams.
// Depends on ppht_pkg, ppht_ctrl, ppht_datapath (and ppht_ram below it).
//
// Requests arrive on s_axis: tuser holds the mode (clear, append vertex,
// query), tdata the point. Every request yields exactly one response on
// m_axis: hit, status (append refused, store full), vertex count after it.
// One request at a time; s_axis_tready is high only while idle, and a new
// request may be taken while the previous response waits in the output reg.
// Clear, refused append, unused mode and a query with fewer than three
// vertices go straight to the response register; a stored append first
// writes the vertex. Otherwise a query first checks the first/last vertex
// closeness through the shared multiplier, then walks the edges (store
// read, operand load, 23 products through the one 34x34 multiplier, drain,
// evaluation) and loads the response; it ends early at the first edge
// that decides a hit.
// Reset (synchronous, active low) empties the store count, restores the
// tolerance registers and drops m_axis_tvalid; the vertex memory is not
// cleared and needs none, as only written entries are read.
// A stalled m_axis holds its response; a finished request then waits and no
// further request is taken until the response goes. Tolerances via APB only
// while the block is idle.
`default_nettype none

module polygon_point_hit_test_top
    import ppht_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,  // [31:0] point_x, [63:32] point_y
    input  wire logic [1:0]        s_axis_tuser,  // [1:0] mode
    // response stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,  // [0] hit, [1] status, [10:2] vertex_count
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_edge_tol, r_cross_tol, r_close_tol;
    logic        cfg_wr;

    // APB write lands in the access phase; always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_tol  <= RST_EDGE_TOL;
            r_cross_tol <= RST_CROSS_TOL;
            r_close_tol <= RST_CLOSE_TOL;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_EDGE_TOL:  r_edge_tol  <= pwdata[15:0];
                CFG_CROSS_TOL: r_cross_tol <= pwdata[15:0];
                CFG_CLOSE_TOL: r_close_tol <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_EDGE_TOL:  prdata = {16'd0, r_edge_tol};
            CFG_CROSS_TOL: prdata = {16'd0, r_cross_tol};
            CFG_CLOSE_TOL: prdata = {16'd0, r_close_tol};
            default:       prdata = '0;
        endcase
    end

    t_cmd                            cmd;
    t_stat                           stat;
    logic [$clog2(MAX_VERTICES)-1:0] addr;
    logic                            hit, status;
    logic [VC_W-1:0]                 vcount;

    // controller: handshake, count, edge walk, response register
    ppht_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_hit       (hit),
        .o_status    (status),
        .o_vcount    (vcount),
        .o_cmd       (cmd),
        .o_addr      (addr),
        .i_stat      (stat)
    );

    // datapath: vertex store, multiplier, per-edge tests
    ppht_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .i_px        (s_axis_tdata[31:0]),
        .i_py        (s_axis_tdata[63:32]),
        .i_edge_tol  (r_edge_tol),
        .i_cross_tol (r_cross_tol),
        .i_close_tol (r_close_tol),
        .o_stat      (stat)
    );

    assign m_axis_tdata = {5'd0, vcount, status, hit};

endmodule

`default_nettype wire

@@ hw/rtl/ppht_checker.sv @@
// Port-level checks of the hit test, bound to the top level.
// Depends on polygon_point_hit_test_top_assert.svh and ppht_pkg.
`default_nettype none
`include "polygon_point_hit_test_top_assert.svh"

module ppht_checker
    import ppht_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    `PPHT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "response dropped while stalled")
    `PPHT_ASSERT(a_hit_xor_status, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "hit on refused append")
    `PPHT_ASSERT(a_count_max, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[10:2] <= VC_W'(MAX_VERTICES)), "vertex count over capacity")
    `PPHT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
    `PPHT_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "response valid after reset")

endmodule

bind polygon_point_hit_test_top ppht_checker #(.MAX_VERTICES(MAX_VERTICES)) u_chk (.*);

`default_nettype wire

@@ verif/polygon_point_hit_test_top_tb.sv @@
// Self-checking testbench for polygon_point_hit_test_top: directed table, then random
// polygons and queries, checked against an exact-arithmetic predictor. Needs ppht_pkg.
`default_nettype none

module polygon_point_hit_test_top_tb
    import ppht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_VERT    = DEF_MAX_VERTICES;
    localparam int RAND_ITEMS  = 1700;
    // cycles without any accepted request or response before giving up;
    // it outlasts a full-store query and a receiver hold-off
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 500;
    localparam int SQ          = 4 << 16;   // side of the directed square, 4.0

    // wide enough for squared products of squared lengths, all exact
    typedef logic signed [191:0] t_wnum;

    typedef struct {
        logic       hit;
        logic       status;
        logic [8:0] count;
    } t_resp;

    typedef struct {
        logic [1:0] mode;
        int         x;
        int         y;
        bit         known;
        t_resp      resp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [31:0]       prdata;
    logic              pready;

    polygon_point_hit_test_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),      // [31:0] point_x, [63:32] point_y
        .s_axis_tuser  (s_user),      // [1:0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata), // [0] hit, [1] status, [10:2] vertex_count
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor state: shadow copy of vertex store and tolerances
    // ---------------------------------------------------------------
    int          shadow_x [NUM_VERT];
    int          shadow_y [NUM_VERT];
    int          shadow_count = 0;
    int unsigned tol_edge  = RST_EDGE_TOL;
    int unsigned tol_cross = RST_CROSS_TOL;
    int unsigned tol_close = RST_CLOSE_TOL;

    t_resp resp_q[$];          // responses still owed by the block
    int    mismatches = 0;
    int    responses_seen = 0;
    int    requests_sent = 0;
    int    queries_sent = 0;
    int    hits_seen = 0;
    int    refusals_seen = 0;
    int    idle_cycles = 0;
    bit    no_idle = 1'b0;     // phase with back-to-back traffic
    bit    hold_req = 1'b0;    // asks the receiver for a long hold-off

    function automatic int sgn(t_wnum v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit near_edge(longint px, longint py, longint bx, longint by,
                                     longint ex, longint ey);
        t_wnum ax, ay, cx, cy, ux, uy, a2, b2, c2, ct2, et2, cr;
        ax = px - bx; ay = py - by; cx = px - ex; cy = py - ey;
        ux = ex - bx; uy = ey - by;
        a2 = ax * ax + ay * ay;
        c2 = cx * cx + cy * cy;
        b2 = ux * ux + uy * uy;
        ct2 = t_wnum'(tol_cross) * t_wnum'(tol_cross);
        et2 = t_wnum'(tol_edge) * t_wnum'(tol_edge);
        if (a2 <= ct2 || c2 <= ct2) return 1'b1;
        if (b2 <= ct2) return a2 <= et2;
        // both end angles at most 90 degrees: perpendicular distance
        if (ax * ux + ay * uy >= 0 && -(cx * ux + cy * uy) >= 0) begin
            cr = ux * ay - uy * ax;
            return cr * cr <= et2 * b2;
        end
        return a2 <= et2 || c2 <= et2;
    endfunction

    // sign of (crossing x at py) - k
    function automatic int cross_vs(longint k, longint py, longint bx, longint by,
                                    longint ex, longint ey);
        t_wnum den, v;
        den = ey - by;
        v = t_wnum'(bx - k) * den + t_wnum'(ex - bx) * t_wnum'(py - by);
        return sgn(v) * sgn(den);
    endfunction

    function automatic bit query_hit(longint px, longint py);
        int     n, eff, prev;
        longint ct, bx, by, ex, ey, miny, maxy, minx, maxx, dy;
        t_wnum  dfx, dfy;
        bit     parity;
        n = shadow_count;
        ct = tol_cross;
        parity = 1'b0;
        if (n < 3) return 1'b0;
        eff = n;
        dfx = longint'(shadow_x[n-1]) - longint'(shadow_x[0]);
        dfy = longint'(shadow_y[n-1]) - longint'(shadow_y[0]);
        // closed polygon given with a repeated first vertex
        if (dfx * dfx + dfy * dfy < t_wnum'(tol_close) * t_wnum'(tol_close)) eff--;
        if (eff < 3) return 1'b0;
        prev = n - 1;
        for (int i = 0; i < n; i++) begin
            bx = shadow_x[prev]; by = shadow_y[prev];
            ex = shadow_x[i];    ey = shadow_y[i];
            prev = i;
            if (near_edge(px, py, bx, by, ex, ey)) return 1'b1;
            dy = (ey > by) ? ey - by : by - ey;
            if (dy > ct) begin
                miny = (by < ey) ? by : ey; maxy = (by < ey) ? ey : by;
                minx = (bx < ex) ? bx : ex; maxx = (bx < ex) ? ex : bx;
                if (py < miny - ct || py > maxy + ct) continue;
                if (cross_vs(minx - ct, py, bx, by, ex, ey) < 0) continue;
                if (cross_vs(maxx + ct, py, bx, by, ex, ey) > 0) continue;
                if (cross_vs(px - ct, py, bx, by, ex, ey) >= 0 &&
                    cross_vs(px + ct, py, bx, by, ex, ey) <= 0) return 1'b1;
                // half-open rule in y for rightward crossings
                if (cross_vs(px, py, bx, by, ex, ey) > 0 && py < maxy - ct &&
                    py >= miny - ct) parity = ~parity;
            end
        end
        return parity;
    endfunction

    // applies one request to the shadow state and returns its response
    function automatic t_resp predict_response(logic [1:0] mode, int x, int y);
        t_resp r;
        r.hit = 1'b0;
        r.status = 1'b0;
        case (mode)
            MODE_CLEAR: shadow_count = 0;
            MODE_APPEND: begin
                if (shadow_count < NUM_VERT) begin
                    shadow_x[shadow_count] = x;
                    shadow_y[shadow_count] = y;
                    shadow_count++;
                end else begin
                    r.status = 1'b1;
                end
            end
            MODE_QUERY: r.hit = query_hit(x, y);
            default: ;
        endcase
        r.count = shadow_count[8:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sends one request; a typed expectation replaces the prediction when given
    task automatic send_request(logic [1:0] mode, int x, int y, bit known = 1'b0,
                                t_resp typed = '{1'b0, 1'b0, 9'd0});
        t_resp r;
        int    gap;
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_response(mode, x, y);
        resp_q.insert(resp_q.size(), known ? typed : r);
        requests_sent++;
        if (mode == MODE_QUERY) queries_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // waits until every owed response is back, plus the block's wind-down
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_EDGE_TOL:  tol_edge  = val;
            CFG_CROSS_TOL: tol_cross = val;
            default:       tol_close = val;
        endcase
    endtask

    function automatic logic [15:0] pick_tol(int phase, int unsigned nominal);
        if (phase == 1) return 16'd0;
        if (phase == 2) return 16'hFFFF;
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'(nominal);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // random small offset around a point of interest
    function automatic int jitter();
        return $urandom_range(0, 24000) - 12000;
    endfunction

    // one polygon built from well-formed appends, then queries near it
    task automatic polygon_round(bit big);
        int nvert, cx, cy, rad, nq, k, px, py, j;
        int vxs[$], vys[$];
        send_request(MODE_CLEAR, 0, 0);
        cx  = $urandom_range(0, 200 << 16) - (100 << 16);
        cy  = $urandom_range(0, 200 << 16) - (100 << 16);
        rad = ($urandom_range(0, 3) == 0) ? $urandom_range(2000, 65536)
                                          : $urandom_range(1 << 16, 20 << 16);
        if (big) nvert = NUM_VERT + 2;
        else if ($urandom_range(0, 9) == 0) nvert = $urandom_range(0, 2);
        else nvert = $urandom_range(3, 12);
        for (int i = 0; i < nvert; i++) begin
            px = cx + $urandom_range(0, 2 * rad) - rad;
            py = cy + $urandom_range(0, 2 * rad) - rad;
            // near-horizontal edges and a repeated closing vertex now and then
            if (i > 0 && $urandom_range(0, 5) == 0)
                py = vys[i-1] + $urandom_range(0, 200) - 100;
            if (i == nvert - 1 && i > 2 && $urandom_range(0, 4) == 0) begin
                px = vxs[0] + $urandom_range(0, 8000) - 4000;
                py = vys[0] + $urandom_range(0, 8000) - 4000;
            end
            vxs.insert(vxs.size(), px);
            vys.insert(vys.size(), py);
            send_request(MODE_APPEND, px, py);
        end
        nq = big ? 2 : $urandom_range(3, 10);
        for (int q = 0; q < nq; q++) begin
            k = $urandom_range(0, 2);
            if (vxs.size() == 0) k = 0;
            if (k == 0) begin
                px = cx + $urandom_range(0, 2 * rad) - rad;
                py = cy + $urandom_range(0, 2 * rad) - rad;
            end else begin
                j = $urandom_range(0, vxs.size() - 1);
                px = vxs[j] + jitter();
                py = vys[j] + jitter();
                if (k == 2) begin
                    // close to the midpoint of the edge ending at vertex j
                    px = int'((longint'(vxs[j]) + vxs[(j + vxs.size() - 1) % vxs.size()]) / 2)
                         + jitter();
                    py = int'((longint'(vys[j]) + vys[(j + vys.size() - 1) % vys.size()]) / 2)
                         + jitter();
                end
            end
            send_request(MODE_QUERY, px, py);
        end
        // noise: any mode, any coordinates
        if ($urandom_range(0, 2) == 0)
            send_request(2'($urandom_range(0, 3)), int'($urandom), int'($urandom));
    endtask

    t_row dir_rows[25];

    initial begin
        int phase;
        bit big_done;
        dir_rows = '{
            // empty store and the unused mode report zero
            '{MODE_QUERY,  0, 0, 1, '{0, 0, 9'd0}},
            '{MODE_UNUSED, 32'h7FFFFFFF, 32'h80000000, 1, '{0, 0, 9'd0}},
            // extreme coordinates
            '{MODE_APPEND, 32'h80000000, 32'h80000000, 1, '{0, 0, 9'd1}},
            '{MODE_APPEND, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, '{0, 0, 9'd2}},
            '{MODE_QUERY,  0, 0, 1, '{0, 0, 9'd2}},
            '{MODE_APPEND, 32'h7FFFFFFF, 32'h80000000, 1, '{0, 0, 9'd3}},
            '{MODE_QUERY,  0, 0, 0, '{0, 0, 9'd0}},
            '{MODE_QUERY,  -1, -1, 0, '{0, 0, 9'd0}},
            '{MODE_CLEAR,  0, 0, 1, '{0, 0, 9'd0}},
            // axis-aligned square
            '{MODE_APPEND, 0, 0, 1, '{0, 0, 9'd1}},
            '{MODE_APPEND, SQ, 0, 1, '{0, 0, 9'd2}},
            '{MODE_APPEND, SQ, SQ, 1, '{0, 0, 9'd3}},
            '{MODE_APPEND, 0, SQ, 1, '{0, 0, 9'd4}},
            '{MODE_QUERY,  SQ / 2, SQ / 2, 0, '{0, 0, 9'd0}},
            '{MODE_QUERY,  2 * SQ, SQ / 2, 0, '{0, 0, 9'd0}},
            '{MODE_QUERY,  SQ / 2, 0, 0, '{0, 0, 9'd0}},
            '{MODE_QUERY,  SQ + 3000, SQ / 2, 0, '{0, 0, 9'd0}},
            '{MODE_QUERY,  SQ, SQ, 0, '{0, 0, 9'd0}},
            // repeated first vertex closes the polygon
            '{MODE_APPEND, 100, 50, 1, '{0, 0, 9'd5}},
            '{MODE_QUERY,  SQ / 2, SQ / 2, 0, '{0, 0, 9'd0}},
            '{MODE_CLEAR,  0, 0, 1, '{0, 0, 9'd0}},
            // three vertices, last on top of the first: too few
            '{MODE_APPEND, 0, 0, 1, '{0, 0, 9'd1}},
            '{MODE_APPEND, SQ, 0, 1, '{0, 0, 9'd2}},
            '{MODE_APPEND, 10, 20, 1, '{0, 0, 9'd3}},
            '{MODE_QUERY,  SQ / 2, 100, 1, '{0, 0, 9'd3}}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y,
                         dir_rows[i].known, dir_rows[i].resp);

        phase = 1;
        big_done = 1'b0;
        while (requests_sent < RAND_ITEMS + 25) begin
            // reconfigure only with the block drained
            wait_drained();
            apb_write(CFG_EDGE_TOL,  pick_tol(phase, RST_EDGE_TOL));
            apb_write(CFG_CROSS_TOL, pick_tol(phase, RST_CROSS_TOL));
            apb_write(CFG_CLOSE_TOL, pick_tol(phase, RST_CLOSE_TOL));
            no_idle = (phase % 5 == 3);
            if (phase == 4) hold_req = 1'b1;
            for (int r = 0; r < 6; r++) begin
                if (!big_done && phase == 6) begin
                    polygon_round(1'b1);
                    big_done = 1'b1;
                end else begin
                    polygon_round(1'b0);
                end
            end
            phase++;
        end
        wait_drained();
        $display("covered %0d requests (%0d queries, %0d hits, %0d full-store refusals)",
                 requests_sent, queries_sent, hits_seen, refusals_seen);
        $display("over %0d tolerance settings, %0d responses checked, %0d mismatches",
                 phase, responses_seen, mismatches);
        if (mismatches == 0) begin
            $display("[polygon_point_hit_test_top] OK");
        end else begin
            $display("[polygon_point_hit_test_top] ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Response side: random back-pressure, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 3) != 0);
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // compare each response with the oldest owed one
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            responses_seen++;
            if (resp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response tdata=%h", m_axis_tdata);
            end else begin
                want = resp_q.pop_front();
                if (want.hit) hits_seen++;
                if (want.status) refusals_seen++;
                if (m_axis_tdata[0] !== want.hit || m_axis_tdata[1] !== want.status ||
                    m_axis_tdata[10:2] !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"response %0d: want hit=%0b status=%0b count=%0d, ",
                                  "got %0b %0b %0d"},
                                 responses_seen, want.hit, want.status, want.count,
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[10:2]);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("[polygon_point_hit_test_top] ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
